// ===== src/tts_pkg.sv =====
// Shared types and constants of the tick task scheduler.
// Used by tts_table and tick_task_scheduler_core; depends on nothing.
package tts_pkg;

  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned ROUND_W  = 16;
  localparam int unsigned BUDGET_W = 32;
  localparam int unsigned TASKS_W  = 7;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } tts_state_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [SLOT_W-1:0]   slot_select;
    logic [15:0]         interval_rounds;
    logic [15:0]         cost_us;
    logic [BUDGET_W-1:0] budget_us;
    logic [BUDGET_W-1:0] elapsed_us;
  } tts_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic                dispatch;
    logic                overrun;
    logic                final_slot;
    logic [BUDGET_W-1:0] budget_left_us;
  } tts_out_t;

  typedef struct packed {
    logic [15:0]        interval;
    logic [15:0]        cost;
    logic [ROUND_W-1:0] last_run;
  } tts_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    tts_entry_t        wr_data;
  } tts_tbl_req_t;

endpackage

// ===== src/tick_task_scheduler_core.sv =====
// Tick task scheduler: a round-start or report beat that evaluates a slot passes
// through ST_EVAL (busy high there, while the registered read of the task table
// returns); a load, an ignored report, a final-slot report or an unused action
// completes without ST_EVAL. Each evaluation result appears on out_data for one cycle
// with out_valid, in the cycle in which busy drops; the receiver cannot stall, so it
// must take every result beat as it comes. There is no clearing pass: the table reads
// as zero after reset. Depends on tts_pkg, tts_table.
module tick_task_scheduler_core #(
  parameter int unsigned NUM_TASKS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  tts_pkg::tts_in_t               in_data,
  output logic                           out_valid,
  output tts_pkg::tts_out_t              out_data,
  input  logic                           cfg_wr_en,
  input  logic [tts_pkg::TASKS_W-1:0]    cfg_wr_data
);
  import tts_pkg::*;

  localparam logic [TASKS_W-1:0] NT = TASKS_W'(NUM_TASKS);

  tts_state_t          state_r, state_nxt;
  logic [ROUND_W-1:0]  round_r, round_nxt;
  logic                active_r, active_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [TASKS_W-1:0]  tasks_r;
  logic                out_valid_r;
  tts_out_t            out_data_r, out_data_nxt;

  tts_tbl_req_t        tbl_req;
  tts_entry_t          ent;

  logic                in_acc;
  logic                do_eval;
  logic [TASKS_W-1:0]  slots_n;
  logic [TASKS_W-1:0]  slot_inc;
  logic                last_slot;
  logic [BUDGET_W-1:0] budget_sub;
  logic [ROUND_W-1:0]  dt;
  logic                due, fits, disp;

  tts_table #(.NUM_TASKS(NUM_TASKS)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tbl_req),
    .rd_entry (ent)
  );

  assign in_acc = start && (state_r == ST_IDLE);

  // clamp slot count to 1..NUM_TASKS
  always_comb begin
    priority if (tasks_r == '0) begin
      slots_n = TASKS_W'(1);
    end else if (tasks_r > NT) begin
      slots_n = NT;
    end else begin
      slots_n = tasks_r;
    end
  end

  assign slot_inc   = {1'b0, slot_r} + TASKS_W'(1);
  assign last_slot  = slot_inc >= slots_n;
  assign budget_sub = (in_data.elapsed_us >= budget_r) ? '0 : budget_r - in_data.elapsed_us;

  // which accepted beats open an evaluation
  assign do_eval = in_acc && ((in_data.action == ACT_START) ||
                   ((in_data.action == ACT_REPORT) && active_r && !last_slot));

  // evaluation of the slot whose entry just came back
  assign dt   = round_r - ent.last_run;
  assign due  = dt >= ent.interval;
  assign fits = {16'b0, ent.cost} <= budget_r;
  assign disp = due && fits;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (do_eval) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs: handshake and table access
  always_comb begin
    busy            = (state_r == ST_EVAL);
    tbl_req         = '0;
    tbl_req.rd_en   = do_eval;
    tbl_req.rd_addr = slot_nxt;
    if (state_r == ST_EVAL) begin
      // record this round as the last run
      tbl_req.wr_en            = disp;
      tbl_req.wr_addr          = slot_r;
      tbl_req.wr_data          = ent;
      tbl_req.wr_data.last_run = round_r;
    end else if (in_acc && (in_data.action == ACT_LOAD) &&
                 ({1'b0, in_data.slot_select} < NT)) begin
      tbl_req.wr_en            = 1'b1;
      tbl_req.wr_addr          = in_data.slot_select;
      tbl_req.wr_data.interval = in_data.interval_rounds;
      tbl_req.wr_data.cost     = in_data.cost_us;
      tbl_req.wr_data.last_run = '0;
    end
  end

  // datapath next values
  always_comb begin
    round_nxt  = round_r;
    active_nxt = active_r;
    slot_nxt   = slot_r;
    budget_nxt = budget_r;
    if (in_acc) begin
      if (in_data.action == ACT_START) begin
        budget_nxt = in_data.budget_us;
        slot_nxt   = '0;
        active_nxt = 1'b1;
      end else if ((in_data.action == ACT_REPORT) && active_r) begin
        budget_nxt = budget_sub;
        if (last_slot) begin
          round_nxt  = round_r + ROUND_W'(1);
          active_nxt = 1'b0;
          slot_nxt   = '0;
        end else begin
          slot_nxt = slot_inc[SLOT_W-1:0];
        end
      end
    end
    out_data_nxt.slot_index     = slot_r;
    out_data_nxt.dispatch       = disp;
    out_data_nxt.overrun        = {1'b0, dt} >= {ent.interval, 1'b0};
    out_data_nxt.final_slot     = last_slot;
    out_data_nxt.budget_left_us = budget_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      active_r    <= 1'b0;
      slot_r      <= '0;
      budget_r    <= '0;
      tasks_r     <= TASKS_W'(4);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      active_r    <= active_nxt;
      slot_r      <= slot_nxt;
      budget_r    <= budget_nxt;
      out_valid_r <= (state_r == ST_EVAL);
      if (cfg_wr_en) begin
        tasks_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EVAL))
    else $error("result beat without a preceding evaluation");

  a_eval_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |=> (state_r == ST_IDLE))
    else $error("evaluation held longer than one cycle");

  a_slot_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, slot_r} < NT))
    else $error("current slot beyond the task table");

  a_eval_needs_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> active_r)
    else $error("evaluation outside an open round");
`endif

endmodule

// ===== src/tts_table.sv =====
// Task table: one synchronous memory of interval, cost and last-run round per slot.
// Per-slot valid bits make unwritten slots read as zero. Depends on tts_pkg.
module tts_table #(
  parameter int unsigned NUM_TASKS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tts_pkg::tts_tbl_req_t req,
  output tts_pkg::tts_entry_t   rd_entry
);
  import tts_pkg::*;

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  tts_entry_t           mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] valid_r;
  tts_entry_t           rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr[IDX_W-1:0]];
      end
    end
  end

  // never-written slot reads as zero
  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule
